FILE: rtl/core/ish_pkg.sv
// Shared types and constants for the instruction shape hash block.
`timescale 1ns / 1ps

package ish_pkg;

  // Start value of the 64-bit FNV-1a style hash
  localparam logic [63:0] FnvBasis = 64'd1469598103934665603;

  // Bytes folded per 64-bit word
  localparam int unsigned WordBytes = 8;
  localparam int unsigned ByteCntW  = $clog2(WordBytes);

  // Tag field positions
  localparam int unsigned RegShift    = 16;
  localparam int unsigned InsideBit   = 32;
  localparam int unsigned OffsetShift = 40;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_OPCODE  = 2'd1,
    KIND_OPERAND = 2'd2,
    KIND_EMPTY   = 2'd3
  } item_kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FUNCTION_START = 3'd0,
    CFG_FUNCTION_END   = 3'd1,
    CFG_REGISTER_TYPE  = 3'd2,
    CFG_NEAR_TYPE      = 3'd3,
    CFG_FAR_TYPE       = 3'd4
  } cfg_idx_e;

  // Control state machine
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_DONE
  } ctrl_state_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] opcode_value;
    logic [7:0]  operand_type;
    logic [15:0] register_number;
    logic [63:0] branch_target;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [63:0] hash_value;
    logic [31:0] instruction_count;
    logic [63:0] size_in_bytes;
  } out_item_t;

  // Configuration register file
  typedef struct packed {
    logic [63:0] function_start;
    logic [63:0] function_end;
    logic [7:0]  register_type_code;
    logic [7:0]  near_type_code;
    logic [7:0]  far_type_code;
  } cfg_t;

  // Fold engine control and status
  typedef struct packed {
    logic start;
    logic clear;
  } fold_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } fold_stat_t;

endpackage

FILE: rtl/core/ish_tag.sv
// Word builder: turns one input transaction into the 64-bit word to fold.
`timescale 1ns / 1ps

module ish_tag import ish_pkg::*; (
  input  in_item_t    item_i,
  input  cfg_t        cfg_i,
  output logic [63:0] word_o
);

  logic        is_reg;
  logic        is_addr;
  logic        in_range;
  logic [63:0] rel;
  logic [63:0] tag;

  // Operand tag: type code, register id, in-function target marker and offset
  always_comb begin
    is_reg   = (item_i.operand_type == cfg_i.register_type_code);
    is_addr  = (item_i.operand_type == cfg_i.near_type_code) ||
               (item_i.operand_type == cfg_i.far_type_code);
    in_range = (item_i.branch_target >= cfg_i.function_start) &&
               (item_i.branch_target <  cfg_i.function_end);
    rel      = item_i.branch_target - cfg_i.function_start;
    tag      = {56'd0, item_i.operand_type};
    if (is_reg) begin
      tag[RegShift +: 16] = item_i.register_number;
    end
    if (is_addr && in_range) begin
      tag[InsideBit] = 1'b1;
      // Offset lands at bit 40; its top forty bits fall off the word
      tag[63:OffsetShift] = rel[63-OffsetShift:0];
    end
  end

  // Select the word by item kind
  always_comb begin
    case (item_i.item_kind)
      KIND_OPCODE:  word_o = {48'd0, item_i.opcode_value};
      KIND_OPERAND: word_o = tag;
      default:      word_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/ish_fold.sv
// Byte-serial FNV-1a fold engine holding the running hash.
`timescale 1ns / 1ps

module ish_fold import ish_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fold_ctrl_t  ctrl_i,
  input  logic [63:0] word_i,
  output fold_stat_t  stat_o,
  output logic [63:0] hash_o
);

  logic [63:0]         word_q, word_d;
  logic [63:0]         hash_q, hash_d;
  logic [ByteCntW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [63:0]         mix;
  logic [63:0]         prod;
  logic                last;

  // xor one byte, then multiply by the prime 2^40 + 2^8 + 0xB3 by shift-add
  always_comb begin
    mix  = hash_q ^ {56'd0, word_q[7:0]};
    prod = mix + (mix << 1) + (mix << 4) + (mix << 5) + (mix << 7) +
           (mix << 8) + (mix << 40);
  end

  assign last = busy_q && (cnt_q == ByteCntW'(WordBytes - 1));

  // Next state of the shift register, byte counter and hash
  always_comb begin
    word_d = word_q;
    hash_d = hash_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      hash_d = prod;
      word_d = {8'd0, word_q[63:8]};
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (ctrl_i.clear) begin
      hash_d = FnvBasis;
    end
    if (ctrl_i.start) begin
      word_d = word_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.last = last;
  assign hash_o      = hash_q;

endmodule

FILE: rtl/core/instruction_shape_hash_top.sv
// Top level: configuration, control state machine, counter and result register.
// An accepted item is folded byte by byte in ST_FOLD, then ST_DONE loads the result register
// once the result slot frees. The input stalls while a word is folded, so a new item waits.
// A begin item needs no fold and can follow every cycle the result slot frees.
// The next item is taken while a finished result waits in the output register.
// Reset (rst_ni low, asynchronous) loads the start value FnvBasis, zeroes the count
// and loads the register defaults: start 0, end 0, register 1, near 6, far 5.
`timescale 1ns / 1ps

module instruction_shape_hash_top import ish_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  cfg_t        cfg_q;
  ctrl_state_e state_q, state_d;
  logic [31:0] insn_cnt_q, insn_cnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q;
  logic        in_acc;
  logic        slot_free;
  logic        out_load;
  logic        is_begin;
  logic [63:0] word;
  logic [63:0] hash;
  fold_ctrl_t  fold_ctrl;
  fold_stat_t  fold_stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_start     <= '0;
      cfg_q.function_end       <= '0;
      cfg_q.register_type_code <= 8'd1;
      cfg_q.near_type_code     <= 8'd6;
      cfg_q.far_type_code      <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FUNCTION_START: cfg_q.function_start     <= cfg_data_i;
        CFG_FUNCTION_END:   cfg_q.function_end       <= cfg_data_i;
        CFG_REGISTER_TYPE:  cfg_q.register_type_code <= cfg_data_i[7:0];
        CFG_NEAR_TYPE:      cfg_q.near_type_code     <= cfg_data_i[7:0];
        CFG_FAR_TYPE:       cfg_q.far_type_code      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Word to fold
  ish_tag u_tag (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .word_o (word)
  );

  // Fold engine
  ish_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fold_ctrl),
    .word_i (word),
    .stat_o (fold_stat),
    .hash_o (hash)
  );

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_begin  = (in_data_i.item_kind == KIND_BEGIN);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = is_begin ? ST_DONE : ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (fold_stat.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          if (in_acc) begin
            state_d = is_begin ? ST_DONE : ST_FOLD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_FOLD: in_stall_o = 1'b1;
      ST_DONE: begin
        in_stall_o = !slot_free;
        out_load   = slot_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign fold_ctrl.start = in_acc && !is_begin;
  assign fold_ctrl.clear = in_acc && is_begin;

  // Instruction counter
  always_comb begin
    insn_cnt_d = insn_cnt_q;
    if (in_acc) begin
      if (is_begin) begin
        insn_cnt_d = '0;
      end else if (in_data_i.item_kind == KIND_OPCODE) begin
        insn_cnt_d = insn_cnt_q + 32'd1;
      end
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      insn_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      insn_cnt_q  <= insn_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.hash_value        <= hash;
      out_q.instruction_count <= insn_cnt_q;
      out_q.size_in_bytes     <= cfg_q.function_end - cfg_q.function_start;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: bench/tb_instruction_shape_hash_top.sv
// Self-checking testbench for the instruction shape hash block.
`timescale 1ns / 1ps

module tb_instruction_shape_hash_top;
  import ish_pkg::*;

  localparam logic [63:0] FnvPrime   = 64'd1099511628211;
  localparam int          CycleLimit = 400000;
  localparam int          SettleCycles = 12;
  localparam int          PhaseItems = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;

  // Directed stimulus row: either a register write or one input transaction
  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [63:0] val;
    in_item_t    item;
    bit          typed;
    logic [63:0] hash;
    logic [31:0] count;
  } row_t;

  // Shadow copy of the register file and of the hash state
  logic [63:0] fn_start   = 64'd0;
  logic [63:0] fn_end     = 64'd0;
  logic [7:0]  reg_code   = 8'd1;
  logic [7:0]  near_code  = 8'd6;
  logic [7:0]  far_code   = 8'd5;
  logic [63:0] hash_acc   = FnvBasis;
  logic [31:0] insn_acc   = 32'd0;

  row_t        dir_rows[$];
  out_item_t   pending_results[$];
  int          errors = 0;
  int          results_seen = 0;
  bit          no_gaps = 1'b0;
  bit          long_hold_done = 1'b0;

  instruction_shape_hash_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Byte-serial FNV-1a fold of one word, low byte first
  function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [63:0] w);
    for (int k = 0; k < 8; k++) begin
      h = (h ^ {56'd0, w[8*k +: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  // Operand tag: type code, register id, in-function flag and target offset
  function automatic logic [63:0] shape_tag(in_item_t it);
    logic [63:0] tag;
    logic [63:0] rel;
    tag = {56'd0, it.operand_type};
    if (it.operand_type == reg_code) begin
      tag |= {48'd0, it.register_number} << RegShift;
    end
    if (it.operand_type == near_code || it.operand_type == far_code) begin
      if (it.branch_target >= fn_start && it.branch_target < fn_end) begin
        rel = it.branch_target - fn_start;
        tag[InsideBit] = 1'b1;
        // upper offset bits fall off the top of the word
        tag |= {32'd0, rel[31:0]} << OffsetShift;
      end
    end
    return tag;
  endfunction

  // Advance the shadow hash state by one transaction and return its result
  function automatic out_item_t advance_hash(in_item_t it);
    out_item_t o;
    case (item_kind_e'(it.item_kind))
      KIND_BEGIN: begin
        hash_acc = FnvBasis;
        insn_acc = 32'd0;
      end
      KIND_OPCODE: begin
        insn_acc = insn_acc + 32'd1;
        hash_acc = fnv_fold(hash_acc, {48'd0, it.opcode_value});
      end
      KIND_OPERAND: hash_acc = fnv_fold(hash_acc, shape_tag(it));
      default:      hash_acc = fnv_fold(hash_acc, 64'd0);
    endcase
    o.hash_value        = hash_acc;
    o.instruction_count = insn_acc;
    o.size_in_bytes     = fn_end - fn_start;
    return o;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t rand_item(item_kind_e k);
    in_item_t it;
    it.item_kind       = k;
    it.opcode_value    = 16'($urandom_range(0, 65535));
    it.operand_type    = 8'($urandom_range(0, 255));
    it.register_number = 16'($urandom_range(0, 65535));
    it.branch_target   = {$urandom, $urandom};
    return it;
  endfunction

  // Branch targets cluster in and around the function range
  function automatic logic [63:0] pick_target();
    logic [63:0] span;
    int r;
    span = fn_end - fn_start;
    r = $urandom_range(0, 99);
    if (r < 55 && fn_end > fn_start) return fn_start + ({$urandom, $urandom} % span);
    if (r < 65) return fn_start;
    if (r < 72) return fn_end;
    if (r < 80) return fn_end - 64'd1;
    if (r < 85) return fn_start - 64'd1;
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t rand_operand();
    in_item_t it;
    int r;
    it = rand_item(KIND_OPERAND);
    r = $urandom_range(0, 99);
    if (r < 35)      it.operand_type = reg_code;
    else if (r < 60) it.operand_type = near_code;
    else if (r < 85) it.operand_type = far_code;
    it.branch_target = pick_target();
    return it;
  endfunction

  function automatic row_t item_row(item_kind_e k, logic [15:0] opc, logic [7:0] typ,
                                    logic [15:0] rg, logic [63:0] tgt);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_FUNCTION_START;
    r.val    = 64'd0;
    r.item   = '{item_kind: k, opcode_value: opc, operand_type: typ,
                 register_number: rg, branch_target: tgt};
    // a begin transaction always lands on the offset basis with a zero count
    r.typed  = (k == KIND_BEGIN);
    r.hash   = FnvBasis;
    r.count  = 32'd0;
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_idx_e idx, logic [63:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.item   = '0;
    r.typed  = 1'b0;
    r.hash   = 64'd0;
    r.count  = 32'd0;
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Register write, mirrored into the shadow copy
  task automatic write_reg(cfg_idx_e idx, logic [63:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_FUNCTION_START: fn_start  = v;
      CFG_FUNCTION_END:   fn_end    = v;
      CFG_REGISTER_TYPE:  reg_code  = v[7:0];
      CFG_NEAR_TYPE:      near_code = v[7:0];
      CFG_FAR_TYPE:       far_code  = v[7:0];
      default: ;
    endcase
  endtask

  // Offer one transaction, wait for acceptance and queue its expected result
  task automatic send_item(in_item_t it, bit typed, logic [63:0] th, logic [31:0] tc);
    int gap;
    out_item_t want;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = advance_hash(it);
    if (typed) begin
      want.hash_value        = th;
      want.instruction_count = tc;
    end
    pending_results.insert(pending_results.size(), want);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every expected result is in, then let the block settle
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Per-phase register setting, extremes included
  task automatic pick_config(int ph);
    logic [63:0] s, e;
    logic [7:0]  rc, nc, fc;
    s  = {$urandom, $urandom};
    rc = 8'($urandom_range(0, 255));
    nc = 8'($urandom_range(0, 255));
    fc = 8'($urandom_range(0, 255));
    case (ph)
      0: e = s + 64'($urandom_range(1, 4096));
      1: begin
        s = 64'd0; e = '1; rc = 8'd0; nc = 8'd255; fc = 8'd0;
      end
      2: begin
        s = '1; e = 64'd0; rc = 8'd255; nc = 8'd255; fc = 8'd0;
      end
      3: e = s;
      4: begin
        e = s + 64'($urandom_range(1, 1 << 20)); nc = rc; fc = rc;
      end
      default: e = s + 64'($urandom_range(1, 1 << 20));
    endcase
    write_reg(CFG_FUNCTION_START, s);
    write_reg(CFG_FUNCTION_END, e);
    write_reg(CFG_REGISTER_TYPE, {56'd0, rc});
    write_reg(CFG_NEAR_TYPE, {56'd0, nc});
    write_reg(CFG_FAR_TYPE, {56'd0, fc});
  endtask

  // Main stimulus
  initial begin : stimulus
    in_item_t it;
    int       sent;
    int       nslots;
    int       roll;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: fold before any begin, empty address range
    add_row(item_row(KIND_OPCODE,  16'h0001, 8'd0, 16'h0, 64'h0));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd6, 16'h0, 64'h0));
    add_row(item_row(KIND_BEGIN,   16'h0,    8'd0, 16'h0, 64'h0));
    // Small function range, default type codes
    add_row(cfg_row(CFG_FUNCTION_START, 64'h0000_0000_0040_0000));
    add_row(cfg_row(CFG_FUNCTION_END,   64'h0000_0000_0041_0000));
    add_row(cfg_row(CFG_REGISTER_TYPE,  64'd1));
    add_row(cfg_row(CFG_NEAR_TYPE,      64'd6));
    add_row(cfg_row(CFG_FAR_TYPE,       64'd5));
    add_row(item_row(KIND_OPCODE,  16'hFFFF, 8'd0,   16'h0,    64'h0));
    add_row(item_row(KIND_OPCODE,  16'h0000, 8'd0,   16'h0,    64'h0));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd1,   16'hFFFF, 64'h0));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd1,   16'h0000, 64'h0));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd6,   16'h0,    64'h40_0000));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd6,   16'h0,    64'h40_FFFF));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd6,   16'h0,    64'h41_0000));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd5,   16'h0,    64'h3F_FFFF));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd5,   16'h0,    64'h40_1234));
    add_row(item_row(KIND_OPERAND, 16'hFFFF, 8'hFF,  16'hFFFF, '1));
    add_row(item_row(KIND_EMPTY,   16'hFFFF, 8'hFF,  16'hFFFF, '1));
    add_row(item_row(KIND_EMPTY,   16'h0,    8'h00,  16'h0,    64'h0));
    add_row(item_row(KIND_BEGIN,   16'hFFFF, 8'hFF,  16'hFFFF, '1));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd0,   16'h0,    64'h0));
    // Full address space; register and near codes collide
    add_row(cfg_row(CFG_FUNCTION_START, 64'd0));
    add_row(cfg_row(CFG_FUNCTION_END,   '1));
    add_row(cfg_row(CFG_REGISTER_TYPE,  64'd7));
    add_row(cfg_row(CFG_NEAR_TYPE,      64'd7));
    add_row(cfg_row(CFG_FAR_TYPE,       64'hFF));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd7,   16'hABCD, 64'hFFFF_FFFF_FFFF_FFFE));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'hFF,  16'h0,    64'h0123_4567_89AB_CDEF));
    add_row(item_row(KIND_OPCODE,  16'h1234, 8'd0,   16'h0,    64'h0));
    // Inverted range: nothing is inside
    add_row(cfg_row(CFG_FUNCTION_START, '1));
    add_row(cfg_row(CFG_FUNCTION_END,   64'd0));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'd7,   16'h5A5A, 64'h0));
    add_row(item_row(KIND_BEGIN,   16'h0,    8'd0,   16'h0,    64'h0));
    add_row(item_row(KIND_OPERAND, 16'h0,    8'hFF,  16'h0,    '1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drop_valid();
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].hash, dir_rows[i].count);
      end
    end

    // Random phases: mostly well-formed functions, some noise
    for (int ph = 0; ph < 7; ph++) begin
      drop_valid();
      drain();
      pick_config(ph);
      no_gaps = (ph == 5);
      sent = 0;
      while (sent < PhaseItems) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          it = rand_item(item_kind_e'($urandom_range(0, 3)));
          send_item(it, 1'b0, 64'd0, 32'd0);
          sent++;
        end else if (roll < 16) begin
          send_item(rand_item(KIND_BEGIN), 1'b0, 64'd0, 32'd0);
          sent++;
        end else begin
          send_item(rand_item(KIND_OPCODE), 1'b0, 64'd0, 32'd0);
          sent++;
          nslots = $urandom_range(0, 3);
          repeat (nslots) begin
            it = ($urandom_range(0, 4) == 0) ? rand_item(KIND_EMPTY) : rand_operand();
            send_item(it, 1'b0, 64'd0, 32'd0);
            sent++;
          end
        end
      end
    end

    drop_valid();
    drain();
    if (errors == 0) begin
      $display("tb_instruction_shape_hash_top OK");
    end else begin
      $display("tb_instruction_shape_hash_top NOT OK");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off to back up the input
  initial begin : result_stall
    int run;
    int hold;
    out_stall_i = 1'b0;
    forever begin
      run = no_gaps ? 50 : $urandom_range(1, 30);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (run - 1) @(negedge clk_i);
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        hold = 400;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: hash_value %h", out_data_o.hash_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.hash_value !== want.hash_value) begin
          $error("hash_value: expected %h, got %h", want.hash_value, out_data_o.hash_value);
          errors++;
        end
        if (out_data_o.instruction_count !== want.instruction_count) begin
          $error("instruction_count: expected %0d, got %0d",
                 want.instruction_count, out_data_o.instruction_count);
          errors++;
        end
        if (out_data_o.size_in_bytes !== want.size_in_bytes) begin
          $error("size_in_bytes: expected %h, got %h",
                 want.size_in_bytes, out_data_o.size_in_bytes);
          errors++;
        end
      end
    end
  end

  // Timeout
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_instruction_shape_hash_top NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ish_pkg.sv
rtl/core/ish_tag.sv
rtl/core/ish_fold.sv
rtl/core/instruction_shape_hash_top.sv
bench/tb_instruction_shape_hash_top.sv
